[rtl/core/dfse_pkg.sv]
// Shared constants, types and codes for the depth-first search engine.
// No dependencies.
package dfse_pkg;

	localparam int NUM_VERTICES = 16;
	localparam int STACK_DEPTH  = 256;

	localparam int VTX_W = (NUM_VERTICES > 1) ? $clog2(NUM_VERTICES) : 1;
	localparam int SA_W  = $clog2(STACK_DEPTH);
	localparam int SP_W  = $clog2(STACK_DEPTH + 1);

	localparam logic MODE_EDGE  = 1'b0;
	localparam logic MODE_START = 1'b1;

	typedef logic [VTX_W-1:0]        vtx_t;
	typedef logic [NUM_VERTICES-1:0] vmask_t;
	typedef logic [SA_W-1:0]         saddr_t;
	typedef logic [SP_W-1:0]         sptr_t;

	typedef struct packed {
		logic   we;
		saddr_t waddr;
		vtx_t   wdata;
		logic   re;
		saddr_t raddr;
	} stk_req_t;

	typedef struct packed {
		logic we;
		vtx_t wrow;
		vtx_t wcol;
		logic wbit;
		vtx_t rrow;
	} adj_req_t;

endpackage

[rtl/core/dfse_stack.sv]
// Vertex stack storage: one write port, one registered read port.
// Depends on dfse_pkg.
module dfse_stack (
	input  logic              clk,
	input  dfse_pkg::stk_req_t req,
	output dfse_pkg::vtx_t    rd_data
);
	import dfse_pkg::*;

	vtx_t mem_q [STACK_DEPTH];
	vtx_t rd_q;

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem_q[req.waddr] <= req.wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (req.re) begin
			rd_q <= mem_q[req.raddr];
		end
	end

	assign rd_data = rd_q;

endmodule

[rtl/core/dfse_adj.sv]
// Adjacency bit matrix, one row of neighbour bits per vertex.
// Single bit write, one row read. Depends on dfse_pkg.
module dfse_adj (
	input  logic               clk,
	input  logic               arst_n,
	input  dfse_pkg::adj_req_t req,
	output dfse_pkg::vmask_t   row
);
	import dfse_pkg::*;

	vmask_t adj_q [NUM_VERTICES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_VERTICES; i++) begin
				adj_q[i] <= '0;
			end
		end else if (req.we) begin
			adj_q[req.wrow][req.wcol] <= req.wbit;
		end
	end

	assign row = adj_q[req.rrow];

endmodule

[rtl/core/iterative_dfs_engine_unit.sv]
// Depth-first search engine top level: sequencer, visited marks, output register.
// Edge write: sets or clears one adjacency bit. Start: each pop passes ST_POP then ST_READ, and each
// visited vertex adds a scan over all NUM_VERTICES neighbours (one neighbour per cycle through one
// compare unit); the walk runs until the stack is empty or overflows, output stalls can hold it,
// and no new item is taken meanwhile.
// Results leave through a one-entry output register; the last one after the walk ends.
// Async reset clears control, adjacency and visited marks; stack contents are not cleared.
module iterative_dfs_engine_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // from_vertex[3:0], to_vertex[7:4], edge_present[8], start_vertex[12:9]
	input  logic [0:0]  s_tuser,   // mode[0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // visit_vertex[3:0]
	output logic        m_tlast,
	output logic [0:0]  m_tuser    // overflow[0]
);
	import dfse_pkg::*;

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_POP    = 3'd1;
	localparam logic [2:0] ST_READ   = 3'd2;
	localparam logic [2:0] ST_SCAN   = 3'd3;
	localparam logic [2:0] ST_FINISH = 3'd4;

	logic [2:0] state_q;
	sptr_t      sp_q;
	vmask_t     visited_q;
	vmask_t     row_q;
	vtx_t       w_q;
	vtx_t       pend_q;
	logic       pend_vld_q;
	logic       full_q;
	logic       out_vld_q;
	logic [3:0] out_vtx_q;
	logic       out_last_q;
	logic       out_ovf_q;

	stk_req_t   stk_req;
	vtx_t       stk_rd;
	adj_req_t   adj_req;
	vmask_t     adj_row;

	logic       in_xfer;
	logic       out_free;
	logic       out_load;
	logic [3:0] in_from;
	logic [3:0] in_to;
	logic       in_present;
	logic [3:0] in_start;
	logic       from_ok;
	logic       to_ok;
	logic       start_ok;
	logic       nb_push;
	logic       st_full;

	assign in_from    = s_tdata[3:0];
	assign in_to      = s_tdata[7:4];
	assign in_present = s_tdata[8];
	assign in_start   = s_tdata[12:9];

	assign from_ok  = 32'({28'd0, in_from})  < 32'(NUM_VERTICES);
	assign to_ok    = 32'({28'd0, in_to})    < 32'(NUM_VERTICES);
	assign start_ok = 32'({28'd0, in_start}) < 32'(NUM_VERTICES);

	assign s_tready = (state_q == ST_IDLE);
	assign in_xfer  = s_tvalid && s_tready;
	assign out_free = !out_vld_q || m_tready;
	assign out_load = pend_vld_q && out_free &&
		(((state_q == ST_READ) && !visited_q[stk_rd]) || (state_q == ST_FINISH));

	assign nb_push  = row_q[w_q] && !visited_q[w_q];
	assign st_full  = (sp_q == SP_W'(STACK_DEPTH));

	always_comb begin
		adj_req.we   = in_xfer && (s_tuser[0] == MODE_EDGE) && from_ok && to_ok;
		adj_req.wrow = VTX_W'(in_from);
		adj_req.wcol = VTX_W'(in_to);
		adj_req.wbit = in_present;
		adj_req.rrow = stk_rd;
	end

	always_comb begin
		stk_req.we    = 1'b0;
		stk_req.waddr = sp_q[SA_W-1:0];
		stk_req.wdata = w_q;
		stk_req.re    = 1'b0;
		stk_req.raddr = SA_W'(sp_q - SP_W'(1));
		unique case (state_q)
			ST_IDLE: begin
				stk_req.we    = in_xfer && (s_tuser[0] == MODE_START) && start_ok;
				stk_req.waddr = '0;
				stk_req.wdata = VTX_W'(in_start);
			end
			ST_POP: begin
				stk_req.re = (sp_q != '0);
			end
			ST_SCAN: begin
				stk_req.we = nb_push && !st_full;
			end
			default: begin
			end
		endcase
	end

	dfse_stack u_stack (
		.clk     (clk),
		.req     (stk_req),
		.rd_data (stk_rd)
	);

	dfse_adj u_adj (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (adj_req),
		.row    (adj_row)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			sp_q       <= '0;
			visited_q  <= '0;
			w_q        <= '0;
			pend_vld_q <= 1'b0;
			full_q     <= 1'b0;
			out_vld_q  <= 1'b0;
		end else begin
			if (out_load) begin
				out_vld_q <= 1'b1;
			end else if (m_tready) begin
				out_vld_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_xfer && (s_tuser[0] == MODE_START)) begin
						visited_q  <= '0;
						pend_vld_q <= 1'b0;
						full_q     <= 1'b0;
						if (start_ok) begin
							sp_q    <= SP_W'(1);
							state_q <= ST_POP;
						end else begin
							sp_q <= '0;
						end
					end
				end
				ST_POP: begin
					if (sp_q == '0) begin
						state_q <= ST_FINISH;
					end else begin
						sp_q    <= sp_q - SP_W'(1);
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					if (visited_q[stk_rd]) begin
						state_q <= ST_POP;
					end else if (!pend_vld_q || out_free) begin
						if (pend_vld_q) begin
							out_vtx_q  <= 4'(pend_q);
							out_last_q <= 1'b0;
							out_ovf_q  <= 1'b0;
						end
						pend_q     <= stk_rd;
						pend_vld_q <= 1'b1;
						visited_q  <= visited_q | (vmask_t'(1) << stk_rd);
						row_q      <= adj_row;
						w_q        <= '0;
						state_q    <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (nb_push && st_full) begin
						full_q  <= 1'b1;
						state_q <= ST_FINISH;
					end else begin
						if (nb_push) begin
							sp_q <= sp_q + SP_W'(1);
						end
						w_q <= w_q + VTX_W'(1);
						if (w_q == VTX_W'(NUM_VERTICES - 1)) begin
							state_q <= ST_POP;
						end
					end
				end
				ST_FINISH: begin
					sp_q <= '0;
					if (!pend_vld_q) begin
						state_q <= ST_IDLE;
					end else if (out_free) begin
						out_vtx_q  <= 4'(pend_q);
						out_last_q <= 1'b1;
						out_ovf_q  <= full_q;
						pend_vld_q <= 1'b0;
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {4'd0, out_vtx_q};
	assign m_tlast  = out_last_q;
	assign m_tuser  = out_ovf_q;

endmodule
